// ----- hdl/array_backed_linked_list_defines.svh -----
// assertion macros for the linked list block checker
// depends on: a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef ARRAY_BACKED_LINKED_LIST_DEFINES_SVH
`define ARRAY_BACKED_LINKED_LIST_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ABLL_ASSERT_IMP(label, ante, cons, msg) \
label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ABLL_ASSERT_NXT(label, ante, cons, msg) \
label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/abll_pkg.sv -----
// shared types and constants for the array-backed linked list
// no dependencies
package abll_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int DATA_W_DEF = 64;

    localparam int ACTION_W  = 3;
    localparam int PREC_W    = 4;
    localparam int PAYLOAD_W = 64;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD_HEAD  = 3'd0,
        ACT_ADD_AFTER = 3'd1,
        ACT_ADD_TAIL  = 3'd2,
        ACT_REM_HEAD  = 3'd3,
        ACT_REM_AFTER = 3'd4,
        ACT_REM_TAIL  = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

endpackage

// ----- hdl/abll_if.sv -----
// valid/ready channel interfaces for list actions and their results
// depends on: abll_pkg
interface abll_in_if;
    logic                           valid;
    logic                           ready;
    logic [abll_pkg::ACTION_W-1:0]  action;
    logic [abll_pkg::PREC_W-1:0]    prec_slot;
    logic [abll_pkg::PAYLOAD_W-1:0] payload;

    modport source (output valid, action, prec_slot, payload, input ready);
    modport sink   (input valid, action, prec_slot, payload, output ready);
endinterface

interface abll_out_if;
    logic                           valid;
    logic                           ready;
    logic [abll_pkg::STATUS_W-1:0]  status;
    logic [abll_pkg::SLOT_W-1:0]    slot_used;
    logic [abll_pkg::PAYLOAD_W-1:0] removed_payload;
    logic [abll_pkg::COUNT_W-1:0]   element_count;

    modport source (output valid, status, slot_used, removed_payload, element_count,
                    input ready);
    modport sink   (input valid, status, slot_used, removed_payload, element_count,
                    output ready);
endinterface

// ----- hdl/abll_free_scan.sv -----
// iterative lowest-free-slot search, one slot tested per cycle
// depends on: nothing
module abll_free_scan #(
    parameter int SLOTS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [SLOTS-1:0]         i_busy,
    output logic                     o_done,
    output logic [$clog2(SLOTS)-1:0] o_idx
);

    localparam int IW = $clog2(SLOTS);

    logic          r_run;
    logic          r_done;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (i_start) begin
                r_run  <= 1'b1;
                r_done <= 1'b0;
                r_idx  <= '0;
            end else if (r_run) begin
                // stop on a free slot or at the last slot
                if (!i_busy[r_idx] || r_idx == IW'(SLOTS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= i_busy[r_idx] ? '0 : r_idx;
                end else begin
                    r_done <= 1'b0;
                    r_idx  <= r_idx + 1'b1;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_idx  = r_res;

endmodule

// ----- hdl/array_backed_linked_list.sv -----
// Singly linked list kept in a table of SLOTS slots. Each transaction on i_in is one action
// (insert at head, after a slot, at tail; remove head, after a slot, tail) and gives one
// result on o_out. The block takes one action at a time and drops ready until its result is
// loaded into the output register; ready returns the cycle after that. A failed action goes
// from S_DECIDE straight to S_DONE; remove head passes S_RM_HEAD and remove after passes
// S_RA1 and S_RA2. Every insert runs the free-slot scan in S_SCAN, then S_INS; insert after
// adds S_AA2 and S_AA3, and insert at tail walks the list to its end. Remove tail walks it
// too, the walk reading one link memory entry per cycle, then passes S_RM_TAIL. The result
// load waits while the previous result is still stalled. With 16 slots the slowest action
// is a tail insert onto 15 elements with slot 15 free. No clearing pass is needed after
// reset: slot busy and link-valid bits are flip-flops cleared by reset.
// depends on: abll_pkg, abll_if, abll_free_scan
module array_backed_linked_list #(
    parameter int SLOTS      = abll_pkg::SLOTS_DEF,
    parameter int DATA_WIDTH = abll_pkg::DATA_W_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    abll_in_if.sink    i_in,
    abll_out_if.source o_out
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_INS,
        S_AA2,
        S_AA3,
        S_WALK,
        S_RM_HEAD,
        S_RA1,
        S_RA2,
        S_RM_TAIL,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [abll_pkg::ACTION_W-1:0]   r_action;
    logic [abll_pkg::PREC_W-1:0]     r_prec;
    logic [DATA_WIDTH-1:0]           r_payload;
    logic                            r_head_valid;
    logic [IW-1:0]                   r_head;
    logic [CW-1:0]                   r_count;
    logic [SLOTS-1:0]                r_busy;
    logic [SLOTS-1:0]                r_has_next;
    logic [IW-1:0]                   r_cur;
    logic [IW-1:0]                   r_prev;
    logic                            r_has_prev;
    logic                            r_use_rd;
    logic [IW-1:0]                   r_free;
    abll_pkg::t_status               r_status;
    logic [IW-1:0]                   r_slot;
    logic [DATA_WIDTH-1:0]           r_rem;

    logic                            r_out_valid;
    logic [abll_pkg::STATUS_W-1:0]   r_out_status;
    logic [abll_pkg::SLOT_W-1:0]     r_out_slot;
    logic [abll_pkg::PAYLOAD_W-1:0]  r_out_rem;
    logic [abll_pkg::COUNT_W-1:0]    r_out_count;

    // link and payload memories, read data registered
    logic [IW-1:0]                   r_link_mem [SLOTS];
    logic [DATA_WIDTH-1:0]           r_pay_mem  [SLOTS];
    logic [IW-1:0]                   r_link_rd;
    logic [DATA_WIDTH-1:0]           r_pay_rd;

    logic                            lk_we;
    logic [IW-1:0]                   lk_waddr;
    logic [IW-1:0]                   lk_wdata;
    logic                            pm_we;
    logic [IW-1:0]                   rd_addr;

    logic [IW-1:0]                   p;
    logic                            prec_ok;
    logic                            full;
    logic [IW-1:0]                   w_cur;
    logic                            scan_start;
    logic                            scan_done;
    logic [IW-1:0]                   scan_idx;
    abll_pkg::t_status               dec_status;
    t_state                          dec_next;

    assign p       = IW'(r_prec);
    assign prec_ok = (32'(r_prec) < SLOTS) && r_busy[p];
    assign full    = (r_count == CW'(SLOTS));
    assign w_cur   = r_use_rd ? r_link_rd : r_cur;

    // action checks and where the sequence goes next
    always_comb begin
        dec_status = abll_pkg::ST_OK;
        dec_next   = S_DONE;
        unique case (abll_pkg::t_action'(r_action))
            abll_pkg::ACT_ADD_HEAD, abll_pkg::ACT_ADD_TAIL: begin
                if (full) dec_status = abll_pkg::ST_FULL;
                else      dec_next   = S_SCAN;
            end
            abll_pkg::ACT_ADD_AFTER: begin
                if (full)          dec_status = abll_pkg::ST_FULL;
                else if (!prec_ok) dec_status = abll_pkg::ST_BAD;
                else               dec_next   = S_SCAN;
            end
            abll_pkg::ACT_REM_HEAD: begin
                if (!r_head_valid) dec_status = abll_pkg::ST_EMPTY;
                else               dec_next   = S_RM_HEAD;
            end
            abll_pkg::ACT_REM_AFTER: begin
                if (!r_head_valid)                dec_status = abll_pkg::ST_EMPTY;
                else if (!prec_ok || !r_has_next[p]) dec_status = abll_pkg::ST_BAD;
                else                              dec_next   = S_RA1;
            end
            abll_pkg::ACT_REM_TAIL: begin
                if (!r_head_valid) dec_status = abll_pkg::ST_EMPTY;
                else               dec_next   = S_WALK;
            end
            default: dec_status = abll_pkg::ST_BAD;
        endcase
    end

    assign scan_start = (r_state == S_DECIDE) && (dec_next == S_SCAN);

    // memory port control
    always_comb begin
        lk_we    = 1'b0;
        lk_waddr = r_free;
        lk_wdata = r_head;
        pm_we    = (r_state == S_INS);
        unique case (r_state)
            S_DECIDE: rd_addr = (abll_pkg::t_action'(r_action) == abll_pkg::ACT_REM_HEAD)
                                ? r_head : p;
            S_RA1:    rd_addr = r_link_rd;
            S_WALK:   rd_addr = w_cur;
            S_INS:    rd_addr = p;
            default:  rd_addr = r_cur;
        endcase
        unique case (r_state)
            S_INS: begin
                lk_we = (abll_pkg::t_action'(r_action) == abll_pkg::ACT_ADD_HEAD);
            end
            S_AA2: begin
                lk_we    = 1'b1;
                lk_wdata = r_link_rd;
            end
            S_AA3: begin
                lk_we    = 1'b1;
                lk_waddr = p;
                lk_wdata = r_free;
            end
            S_WALK: begin
                lk_we    = !r_has_next[w_cur] &&
                           (abll_pkg::t_action'(r_action) == abll_pkg::ACT_ADD_TAIL);
                lk_waddr = w_cur;
                lk_wdata = r_free;
            end
            S_RA2: begin
                lk_we    = 1'b1;
                lk_waddr = p;
                lk_wdata = r_link_rd;
            end
            default: lk_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (lk_we) r_link_mem[lk_waddr] <= lk_wdata;
        if (pm_we) r_pay_mem[r_free] <= r_payload;
        r_link_rd <= r_link_mem[rd_addr];
        r_pay_rd  <= r_pay_mem[rd_addr];
    end

    abll_free_scan #(
        .SLOTS (SLOTS)
    ) u_free_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_busy  (r_busy),
        .o_done  (scan_done),
        .o_idx   (scan_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head_valid <= 1'b0;
            r_head       <= '0;
            r_count      <= '0;
            r_busy       <= '0;
            r_has_next   <= '0;
            r_use_rd     <= 1'b0;
            r_has_prev   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_out.ready && (r_state != S_DONE)) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_action  <= i_in.action;
                        r_prec    <= i_in.prec_slot;
                        r_payload <= i_in.payload[DATA_WIDTH-1:0];
                        r_state   <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_status   <= dec_status;
                    r_slot     <= '0;
                    r_rem      <= '0;
                    r_cur      <= r_head;
                    r_use_rd   <= 1'b0;
                    r_has_prev <= 1'b0;
                    r_state    <= dec_next;
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_free  <= scan_idx;
                        r_state <= S_INS;
                    end
                end
                S_INS: begin
                    r_busy[r_free] <= 1'b1;
                    r_count        <= r_count + 1'b1;
                    r_slot         <= r_free;
                    unique case (abll_pkg::t_action'(r_action))
                        abll_pkg::ACT_ADD_HEAD: begin
                            r_has_next[r_free] <= r_head_valid;
                            r_head             <= r_free;
                            r_head_valid       <= 1'b1;
                            r_state            <= S_DONE;
                        end
                        abll_pkg::ACT_ADD_AFTER: r_state <= S_AA2;
                        default: begin
                            // new tail has no successor
                            r_has_next[r_free] <= 1'b0;
                            if (!r_head_valid) begin
                                r_head       <= r_free;
                                r_head_valid <= 1'b1;
                                r_state      <= S_DONE;
                            end else begin
                                r_cur    <= r_head;
                                r_use_rd <= 1'b0;
                                r_state  <= S_WALK;
                            end
                        end
                    endcase
                end
                S_AA2: begin
                    // new slot inherits the successor of the preceding slot
                    r_has_next[r_free] <= r_has_next[p];
                    r_state            <= S_AA3;
                end
                S_AA3: begin
                    r_has_next[p] <= 1'b1;
                    r_state       <= S_DONE;
                end
                S_WALK: begin
                    if (r_has_next[w_cur]) begin
                        r_prev     <= w_cur;
                        r_has_prev <= 1'b1;
                        r_use_rd   <= 1'b1;
                    end else begin
                        r_cur    <= w_cur;
                        r_use_rd <= 1'b0;
                        if (abll_pkg::t_action'(r_action) == abll_pkg::ACT_ADD_TAIL) begin
                            r_has_next[w_cur] <= 1'b1;
                            r_state           <= S_DONE;
                        end else begin
                            r_state <= S_RM_TAIL;
                        end
                    end
                end
                S_RM_HEAD: begin
                    r_head_valid      <= r_has_next[r_cur];
                    r_head            <= r_has_next[r_cur] ? r_link_rd : '0;
                    r_busy[r_cur]     <= 1'b0;
                    r_has_next[r_cur] <= 1'b0;
                    r_count           <= r_count - 1'b1;
                    r_slot            <= r_cur;
                    r_rem             <= r_pay_rd;
                    r_state           <= S_DONE;
                end
                S_RA1: begin
                    r_cur   <= r_link_rd;
                    r_state <= S_RA2;
                end
                S_RA2: begin
                    // unlink the successor of the preceding slot
                    r_has_next[p]     <= r_has_next[r_cur];
                    r_busy[r_cur]     <= 1'b0;
                    r_count           <= r_count - 1'b1;
                    r_slot            <= r_cur;
                    r_rem             <= r_pay_rd;
                    r_state           <= S_DONE;
                end
                S_RM_TAIL: begin
                    if (r_has_prev) begin
                        r_has_next[r_prev] <= 1'b0;
                    end else begin
                        r_head_valid <= 1'b0;
                        r_head       <= '0;
                    end
                    r_busy[r_cur]     <= 1'b0;
                    r_count           <= r_count - 1'b1;
                    r_slot            <= r_cur;
                    r_rem             <= r_pay_rd;
                    r_state           <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_slot   <= abll_pkg::SLOT_W'(r_slot);
                        r_out_rem    <= abll_pkg::PAYLOAD_W'(r_rem);
                        r_out_count  <= abll_pkg::COUNT_W'(r_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out_status;
    assign o_out.slot_used       = r_out_slot;
    assign o_out.removed_payload = r_out_rem;
    assign o_out.element_count   = r_out_count;

endmodule

// ----- hdl/abll_checker.sv -----
// port-level checks for the linked list block, bound to the top level
// depends on: abll_pkg, array_backed_linked_list_defines.svh, array_backed_linked_list
`include "array_backed_linked_list_defines.svh"

module abll_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [abll_pkg::STATUS_W-1:0]  i_status,
    input logic [abll_pkg::SLOT_W-1:0]    i_slot_used,
    input logic [abll_pkg::PAYLOAD_W-1:0] i_removed_payload,
    input logic [abll_pkg::COUNT_W-1:0]   i_element_count
);

    // a stalled result keeps its fields
    `ABLL_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_slot_used) && $stable(i_removed_payload) && $stable(i_element_count), "result changed while stalled")

    // one action at a time
    `ABLL_ASSERT_NXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready, "ready held after accepting an action")

    // failed action reports no slot and no payload
    `ABLL_ASSERT_IMP(a_fail_clean, i_out_valid && (i_status != abll_pkg::ST_OK), (i_slot_used == '0) && (i_removed_payload == '0), "failed action reported slot or payload")

    // empty status only with no elements
    `ABLL_ASSERT_IMP(a_empty_count, i_out_valid && (i_status == abll_pkg::ST_EMPTY), i_element_count == '0, "empty status with nonzero count")

endmodule

bind array_backed_linked_list abll_checker u_abll_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_status          (o_out.status),
    .i_slot_used       (o_out.slot_used),
    .i_removed_payload (o_out.removed_payload),
    .i_element_count   (o_out.element_count)
);
